>>> hw/rtl/dge_pkg.sv
// shared types, constants and fixed-point helpers for the determinant block
package dge_pkg;

  localparam int unsigned MAX_DIM = 8;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned DIV_CYC = 96;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;
  localparam logic [DATA_W-1:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [DATA_W-1:0] Q_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] Q_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  // datapath operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LD_A,
    DP_LD_B,
    DP_LD_T,
    DP_A_FROM_ACC,
    DP_B_FROM_M,
    DP_T_FROM_MRES,
    DP_ACC_RD,
    DP_ACC_ONE,
    DP_ACC_ZERO,
    DP_ACC_MRES,
    DP_ACC_SUB_T,
    DP_ACC_NEG,
    DP_MUL_GO,
    DP_DIV_GO,
    DP_FLIP,
    DP_OUT_LOAD
  } dp_op_e;

  // source of the matrix store write data
  typedef enum logic [2:0] {
    WR_ELEM,
    WR_ZERO,
    WR_A,
    WR_T,
    WR_SUB
  } wr_sel_e;

  typedef struct packed {
    dp_op_e            op;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_e           wr_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic mul_busy;
    logic div_busy;
    logic out_full;
  } dp_stat_t;

  // magnitude of a signed word, most negative maps to 2^63
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // apply sign to a magnitude with saturation, returns {sat, value}
  function automatic logic [DATA_W:0] make_signed(input logic [DATA_W-1:0] m,
                                                  input logic neg, input logic over);
    logic [DATA_W:0] res;
    if (neg) begin
      if (over || (m > Q_MIN)) res = {1'b1, Q_MIN};
      else res = {1'b0, ~m + 1'b1};
    end else begin
      if (over || m[DATA_W-1]) res = {1'b1, Q_MAX};
      else res = {1'b0, m};
    end
    return res;
  endfunction

  // saturating a - b, returns {sat, value}
  function automatic logic [DATA_W:0] sat_sub(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic [DATA_W:0] diff;
    logic [DATA_W:0] res;
    diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (diff[DATA_W] != diff[DATA_W-1]) res = {1'b1, diff[DATA_W] ? Q_MIN : Q_MAX};
    else res = {1'b0, diff[DATA_W-1:0]};
    return res;
  endfunction

endpackage

>>> hw/rtl/dge_datapath.sv
// matrix store, operand registers, sequential multiplier and divider, result register
module dge_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dge_pkg::dp_cmd_t               cmd_i,
  input  logic [dge_pkg::ELEM_W-1:0]     elem_i,
  input  logic                           out_ready_i,
  output dge_pkg::dp_stat_t              stat_o,
  output logic                           out_valid_o,
  output logic [dge_pkg::DATA_W-1:0]     det_o,
  output logic                           sat_o
);

  logic [dge_pkg::DATA_W-1:0] mem_q [dge_pkg::DEPTH];
  logic [dge_pkg::DATA_W-1:0] rdata_q, a_q, b_q, m_q, t_q, acc_q, mres_q;
  logic [dge_pkg::DATA_W-1:0] det_q;
  logic                       sign_q, sat_seen_q, out_sat_q, out_valid_q;

  // multiplier state
  logic [dge_pkg::DATA_W-1:0]   mua_q, mub_q, pp_q;
  logic [2*dge_pkg::DATA_W-1:0] prod_q;
  logic                         mneg_q, mbusy_q;
  logic [2:0]                   mcnt_q;
  logic [1:0]                   psh_q;

  // divider state
  logic [dge_pkg::DATA_W-1:0]  dden_q, drem_q;
  logic [dge_pkg::DIV_CYC-1:0] dnum_q, dq_q;
  logic                        dneg_q, dbusy_q;
  logic [6:0]                  dcnt_q;

  logic [dge_pkg::DATA_W-1:0]  wdata;
  logic [dge_pkg::DATA_W:0]    sub_res, subt_res, neg_res, mul_fin, div_fin;
  logic [31:0]                 mpart_a, mpart_b;
  logic [dge_pkg::DATA_W:0]    rem2, rem_sub;
  logic                        dge_bit, div_last, mul_last, sat_set;
  logic [dge_pkg::DIV_CYC-1:0] q_new;
  logic [1:0]                  psh_d;

  // arithmetic around the operand registers
  assign sub_res  = dge_pkg::sat_sub(a_q, mres_q);
  assign subt_res = dge_pkg::sat_sub(t_q, mres_q);
  assign neg_res  = dge_pkg::sat_sub('0, acc_q);

  // multiplier partial product select and final rounding
  assign mpart_a  = mcnt_q[0] ? mua_q[63:32] : mua_q[31:0];
  assign mpart_b  = mcnt_q[1] ? mub_q[63:32] : mub_q[31:0];
  assign psh_d    = {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
  assign mul_last = mbusy_q && (mcnt_q == 3'd5);
  assign mul_fin  = dge_pkg::make_signed(prod_q[95:32], mneg_q, |prod_q[127:96]);

  // one restoring divide step
  assign rem2     = {drem_q, dnum_q[dge_pkg::DIV_CYC-1]};
  assign rem_sub  = rem2 - {1'b0, dden_q};
  assign dge_bit  = rem2 >= {1'b0, dden_q};
  assign q_new    = {dq_q[dge_pkg::DIV_CYC-2:0], dge_bit};
  assign div_last = dbusy_q && (dcnt_q == 7'(dge_pkg::DIV_CYC - 1));
  assign div_fin  = dge_pkg::make_signed(q_new[63:0], dneg_q, |q_new[95:64]);

  // store write data
  always_comb begin
    case (cmd_i.wr_sel)
      dge_pkg::WR_ELEM: wdata = {{16{elem_i[31]}}, elem_i, 16'h0000};
      dge_pkg::WR_ZERO: wdata = '0;
      dge_pkg::WR_A:    wdata = a_q;
      dge_pkg::WR_T:    wdata = t_q;
      dge_pkg::WR_SUB:  wdata = sub_res[dge_pkg::DATA_W-1:0];
      default:          wdata = '0;
    endcase
  end

  // any saturation in this cycle
  assign sat_set = (mul_last && mul_fin[dge_pkg::DATA_W])
                || (div_last && div_fin[dge_pkg::DATA_W])
                || (cmd_i.wr_en && (cmd_i.wr_sel == dge_pkg::WR_SUB)
                    && sub_res[dge_pkg::DATA_W])
                || ((cmd_i.op == dge_pkg::DP_ACC_SUB_T) && subt_res[dge_pkg::DATA_W])
                || ((cmd_i.op == dge_pkg::DP_ACC_NEG) && sign_q && neg_res[dge_pkg::DATA_W]);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q     <= 1'b0;
      mcnt_q      <= '0;
      dbusy_q     <= 1'b0;
      dcnt_q      <= '0;
      sign_q      <= 1'b0;
      sat_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mbusy_q) begin
        mcnt_q <= mcnt_q + 3'd1;
        if (mul_last) mbusy_q <= 1'b0;
      end else if (cmd_i.op == dge_pkg::DP_MUL_GO) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end
      if (dbusy_q) begin
        dcnt_q <= dcnt_q + 7'd1;
        if (div_last) dbusy_q <= 1'b0;
      end else if (cmd_i.op == dge_pkg::DP_DIV_GO) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end
      if (cmd_i.op == dge_pkg::DP_OUT_LOAD) begin
        sign_q     <= 1'b0;
        sat_seen_q <= 1'b0;
      end else begin
        if (cmd_i.op == dge_pkg::DP_FLIP) sign_q <= ~sign_q;
        if (sat_set) sat_seen_q <= 1'b1;
      end
      if (cmd_i.op == dge_pkg::DP_OUT_LOAD) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // matrix store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.wr_addr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem_q[cmd_i.rd_addr];
  end

  // operand, arithmetic and result payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dge_pkg::DP_LD_A:        a_q   <= rdata_q;
      dge_pkg::DP_LD_B:        b_q   <= rdata_q;
      dge_pkg::DP_LD_T:        t_q   <= rdata_q;
      dge_pkg::DP_A_FROM_ACC:  a_q   <= acc_q;
      dge_pkg::DP_B_FROM_M:    b_q   <= m_q;
      dge_pkg::DP_T_FROM_MRES: t_q   <= mres_q;
      dge_pkg::DP_ACC_RD:      acc_q <= rdata_q;
      dge_pkg::DP_ACC_ONE:     acc_q <= dge_pkg::ONE_Q32;
      dge_pkg::DP_ACC_ZERO:    acc_q <= '0;
      dge_pkg::DP_ACC_MRES:    acc_q <= mres_q;
      dge_pkg::DP_ACC_SUB_T:   acc_q <= subt_res[dge_pkg::DATA_W-1:0];
      dge_pkg::DP_ACC_NEG: begin
        if (sign_q) acc_q <= neg_res[dge_pkg::DATA_W-1:0];
      end
      dge_pkg::DP_MUL_GO: begin
        mua_q  <= dge_pkg::mag(a_q);
        mub_q  <= dge_pkg::mag(b_q);
        mneg_q <= a_q[63] ^ b_q[63];
        prod_q <= '0;
      end
      dge_pkg::DP_DIV_GO: begin
        dden_q <= dge_pkg::mag(b_q);
        dnum_q <= {dge_pkg::mag(a_q), 32'h0000_0000};
        drem_q <= '0;
        dq_q   <= '0;
        dneg_q <= a_q[63] ^ b_q[63];
      end
      dge_pkg::DP_OUT_LOAD: begin
        det_q     <= acc_q;
        out_sat_q <= sat_seen_q;
      end
      default: ;
    endcase

    // multiplier: four 32x32 partial products, each registered then accumulated
    if (mbusy_q) begin
      if (mcnt_q <= 3'd3) begin
        pp_q  <= mpart_a * mpart_b;
        psh_q <= psh_d;
      end
      if ((mcnt_q >= 3'd1) && (mcnt_q <= 3'd4)) begin
        prod_q <= prod_q + ({64'h0, pp_q} << {psh_q, 5'b00000});
      end
      if (mul_last) mres_q <= mul_fin[dge_pkg::DATA_W-1:0];
    end

    // divider: one quotient bit per cycle
    if (dbusy_q) begin
      drem_q <= dge_bit ? rem_sub[dge_pkg::DATA_W-1:0] : rem2[dge_pkg::DATA_W-1:0];
      dq_q   <= q_new;
      dnum_q <= {dnum_q[dge_pkg::DIV_CYC-2:0], 1'b0};
      if (div_last) m_q <= div_fin[dge_pkg::DATA_W-1:0];
    end
  end

  // status back to the controller
  assign stat_o.a_zero   = (a_q == '0);
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.mul_busy = mbusy_q;
  assign stat_o.div_busy = dbusy_q;
  assign stat_o.out_full = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign det_o       = det_q;
  assign sat_o       = out_sat_q;

endmodule

>>> hw/rtl/dge_ctrl.sv
// controller: element loading, clearing, elimination sequencing and result hand-off
module dge_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dge_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  input  dge_pkg::dp_stat_t             stat_i,
  output dge_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic [5:0] {
    S_LOAD, S_CLEAR, S_START,
    S_N1_RD, S_N1_CAP,
    S_N2_RD0, S_N2_RD3, S_N2_CAPB1, S_N2_GO1, S_N2_W1,
    S_N2_RD1, S_N2_RD2, S_N2_CAPB2, S_N2_GO2, S_N2_W2,
    S_PIV_RD, S_PIV_CAP, S_PIV_CHK,
    S_SR_RD, S_SR_CAP, S_SR_CHK,
    S_SW_RDJ, S_SW_RDR, S_SW_CAP, S_SW_WJ, S_SW_WR,
    S_RW_PRD, S_RW_ARD, S_RW_ACAP, S_DIV_GO, S_DIV_W,
    S_K_RDJ, S_K_CAP, S_K_GO, S_K_W, S_K_RDI, S_K_ICAP, S_K_WR,
    S_DG_INIT, S_DG_RD, S_DG_CAP, S_DG_A, S_DG_GO, S_DG_W,
    S_NEG, S_OUT
  } state_e;

  state_e                        state_q, state_d;
  logic [dge_pkg::DIM_W-1:0]     dim_q, n_q, n_d, eff_n, n_m1, n_m2;
  logic [dge_pkg::CNT_W-1:0]     lc_q, lc_d, lc_inc, tot_cur, tot_n;
  logic [dge_pkg::IDX_W-1:0]     j_q, j_d, i_q, i_d, k_q, k_d, r_q, r_d;
  logic                          k_end, i_end, j_end, r_end;

  // linear store address of a row and column
  function automatic logic [dge_pkg::ADDR_W-1:0] mat_addr(
      input logic [dge_pkg::IDX_W-1:0] row, input logic [dge_pkg::IDX_W-1:0] col,
      input logic [dge_pkg::DIM_W-1:0] n);
    logic [dge_pkg::CNT_W-1:0] lin;
    lin = {4'b0000, row} * {3'b000, n} + {4'b0000, col};
    return lin[dge_pkg::ADDR_W-1:0];
  endfunction

  // effective size, zero acts as one and large values clamp
  always_comb begin
    if (dim_q == '0) eff_n = 4'd1;
    else if (dim_q > 4'(dge_pkg::MAX_DIM)) eff_n = 4'(dge_pkg::MAX_DIM);
    else eff_n = dim_q;
  end

  assign tot_cur = {3'b000, eff_n} * {3'b000, eff_n};
  assign tot_n   = {3'b000, n_q} * {3'b000, n_q};
  assign lc_inc  = lc_q + 7'd1;
  assign n_m1    = n_q - 4'd1;
  assign n_m2    = n_q - 4'd2;
  assign k_end   = ({1'b0, k_q} == n_m1);
  assign i_end   = ({1'b0, i_q} == n_m1);
  assign r_end   = ({1'b0, r_q} == n_m1);
  assign j_end   = ({1'b0, j_q} == n_m2);
  assign in_ready_o = (state_q == S_LOAD);

  // next state, counters and datapath commands
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    lc_d    = lc_q;
    j_d     = j_q;
    i_d     = i_q;
    k_d     = k_q;
    r_d     = r_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (lc_q < tot_cur) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = lc_q[dge_pkg::ADDR_W-1:0];
            cmd_o.wr_sel  = dge_pkg::WR_ELEM;
            lc_d          = lc_inc;
          end
          if (in_last_i) begin
            n_d = eff_n;
            if (lc_d < tot_cur) state_d = S_CLEAR;
            else state_d = S_START;
          end
        end
      end
      // zero the positions that were never loaded
      S_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = lc_q[dge_pkg::ADDR_W-1:0];
        cmd_o.wr_sel  = dge_pkg::WR_ZERO;
        lc_d          = lc_inc;
        if (lc_inc == tot_n) state_d = S_START;
      end
      S_START: begin
        j_d = '0;
        case (n_q)
          4'd1:    state_d = S_N1_RD;
          4'd2:    state_d = S_N2_RD0;
          default: state_d = S_PIV_RD;
        endcase
      end
      // single element
      S_N1_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        state_d       = S_N1_CAP;
      end
      S_N1_CAP: begin
        cmd_o.op = dge_pkg::DP_ACC_RD;
        state_d  = S_OUT;
      end
      // two by two cross product
      S_N2_RD0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = 6'd0;
        state_d       = S_N2_RD3;
      end
      S_N2_RD3: begin
        cmd_o.op      = dge_pkg::DP_LD_A;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = 6'd3;
        state_d       = S_N2_CAPB1;
      end
      S_N2_CAPB1: begin
        cmd_o.op = dge_pkg::DP_LD_B;
        state_d  = S_N2_GO1;
      end
      S_N2_GO1: begin
        cmd_o.op = dge_pkg::DP_MUL_GO;
        state_d  = S_N2_W1;
      end
      S_N2_W1: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = dge_pkg::DP_T_FROM_MRES;
          state_d  = S_N2_RD1;
        end
      end
      S_N2_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = 6'd1;
        state_d       = S_N2_RD2;
      end
      S_N2_RD2: begin
        cmd_o.op      = dge_pkg::DP_LD_A;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = 6'd2;
        state_d       = S_N2_CAPB2;
      end
      S_N2_CAPB2: begin
        cmd_o.op = dge_pkg::DP_LD_B;
        state_d  = S_N2_GO2;
      end
      S_N2_GO2: begin
        cmd_o.op = dge_pkg::DP_MUL_GO;
        state_d  = S_N2_W2;
      end
      S_N2_W2: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = dge_pkg::DP_ACC_SUB_T;
          state_d  = S_OUT;
        end
      end
      // pivot of column j
      S_PIV_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(j_q, j_q, n_q);
        state_d       = S_PIV_CAP;
      end
      S_PIV_CAP: begin
        cmd_o.op = dge_pkg::DP_LD_B;
        state_d  = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (stat_i.b_zero) begin
          r_d     = j_q + 3'd1;
          state_d = S_SR_RD;
        end else begin
          i_d     = j_q + 3'd1;
          state_d = S_RW_PRD;
        end
      end
      // search below for a nonzero entry
      S_SR_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(r_q, j_q, n_q);
        state_d       = S_SR_CAP;
      end
      S_SR_CAP: begin
        cmd_o.op = dge_pkg::DP_LD_A;
        state_d  = S_SR_CHK;
      end
      S_SR_CHK: begin
        if (stat_i.a_zero) begin
          if (r_end) begin
            cmd_o.op = dge_pkg::DP_ACC_ZERO;
            state_d  = S_OUT;
          end else begin
            r_d     = r_q + 3'd1;
            state_d = S_SR_RD;
          end
        end else begin
          cmd_o.op = dge_pkg::DP_FLIP;
          k_d      = '0;
          state_d  = S_SW_RDJ;
        end
      end
      // swap rows j and r
      S_SW_RDJ: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(j_q, k_q, n_q);
        state_d       = S_SW_RDR;
      end
      S_SW_RDR: begin
        cmd_o.op      = dge_pkg::DP_LD_T;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(r_q, k_q, n_q);
        state_d       = S_SW_CAP;
      end
      S_SW_CAP: begin
        cmd_o.op = dge_pkg::DP_LD_A;
        state_d  = S_SW_WJ;
      end
      S_SW_WJ: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = mat_addr(j_q, k_q, n_q);
        cmd_o.wr_sel  = dge_pkg::WR_A;
        state_d       = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = mat_addr(r_q, k_q, n_q);
        cmd_o.wr_sel  = dge_pkg::WR_T;
        if (k_end) begin
          state_d = S_PIV_RD;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_SW_RDJ;
        end
      end
      // row factor: entry over pivot
      S_RW_PRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(j_q, j_q, n_q);
        state_d       = S_RW_ARD;
      end
      S_RW_ARD: begin
        cmd_o.op      = dge_pkg::DP_LD_B;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(i_q, j_q, n_q);
        state_d       = S_RW_ACAP;
      end
      S_RW_ACAP: begin
        cmd_o.op = dge_pkg::DP_LD_A;
        state_d  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.op = dge_pkg::DP_DIV_GO;
        state_d  = S_DIV_W;
      end
      S_DIV_W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = dge_pkg::DP_B_FROM_M;
          k_d      = '0;
          state_d  = S_K_RDJ;
        end
      end
      // row i minus factor times row j, one column at a time
      S_K_RDJ: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(j_q, k_q, n_q);
        state_d       = S_K_CAP;
      end
      S_K_CAP: begin
        cmd_o.op = dge_pkg::DP_LD_A;
        state_d  = S_K_GO;
      end
      S_K_GO: begin
        cmd_o.op = dge_pkg::DP_MUL_GO;
        state_d  = S_K_W;
      end
      S_K_W: begin
        if (!stat_i.mul_busy) state_d = S_K_RDI;
      end
      S_K_RDI: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(i_q, k_q, n_q);
        state_d       = S_K_ICAP;
      end
      S_K_ICAP: begin
        cmd_o.op = dge_pkg::DP_LD_A;
        state_d  = S_K_WR;
      end
      S_K_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = mat_addr(i_q, k_q, n_q);
        cmd_o.wr_sel  = dge_pkg::WR_SUB;
        if (!k_end) begin
          k_d     = k_q + 3'd1;
          state_d = S_K_RDJ;
        end else if (!i_end) begin
          i_d     = i_q + 3'd1;
          state_d = S_RW_PRD;
        end else if (!j_end) begin
          j_d     = j_q + 3'd1;
          state_d = S_PIV_RD;
        end else begin
          state_d = S_DG_INIT;
        end
      end
      // product of the diagonal
      S_DG_INIT: begin
        cmd_o.op = dge_pkg::DP_ACC_ONE;
        i_d      = '0;
        state_d  = S_DG_RD;
      end
      S_DG_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = mat_addr(i_q, i_q, n_q);
        state_d       = S_DG_CAP;
      end
      S_DG_CAP: begin
        cmd_o.op = dge_pkg::DP_LD_B;
        state_d  = S_DG_A;
      end
      S_DG_A: begin
        cmd_o.op = dge_pkg::DP_A_FROM_ACC;
        state_d  = S_DG_GO;
      end
      S_DG_GO: begin
        cmd_o.op = dge_pkg::DP_MUL_GO;
        state_d  = S_DG_W;
      end
      S_DG_W: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = dge_pkg::DP_ACC_MRES;
          if (i_end) begin
            state_d = S_NEG;
          end else begin
            i_d     = i_q + 3'd1;
            state_d = S_DG_RD;
          end
        end
      end
      S_NEG: begin
        cmd_o.op = dge_pkg::DP_ACC_NEG;
        state_d  = S_OUT;
      end
      // hand the result to the output register
      S_OUT: begin
        if (!stat_i.out_full) begin
          cmd_o.op = dge_pkg::DP_OUT_LOAD;
          lc_d     = '0;
          state_d  = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // state, counters and size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      dim_q   <= dge_pkg::DIM_RESET;
      n_q     <= dge_pkg::DIM_RESET;
      lc_q    <= '0;
      j_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      lc_q    <= lc_d;
      j_q     <= j_d;
      i_q     <= i_d;
      k_q     <= k_d;
      r_q     <= r_d;
      if (cfg_valid_i) dim_q <= cfg_data_i;
    end
  end

endmodule

>>> hw/rtl/determinant_gauss_elimination_top.sv
// top level of the fixed-point determinant block
//
// Input stream: one Q16.16 matrix element per transfer in row-major order,
// tlast on the final element. Elements are taken one per cycle while loading;
// elements beyond dimension squared are dropped, and a tlast before the matrix
// is full treats the missing positions as zero (cleared one per cycle).
// Output stream: one transfer per matrix, tdata the Q32.32 determinant,
// tuser set when a product, quotient or difference saturated.
// Config channel: cfg_data_i sets the dimension (0 acts as 1, above 8 as 8);
// write it only while no matrix is in progress. Reset sets dimension 3.
// For sizes 3 and above the time to tvalid is set by the bit-serial restoring
// divider (one division per row below each pivot) and the sequential multiply
// (one per column of each row update); cleared positions and row swaps add
// to it. tready on the input stays low while a matrix is computed. A finished
// result waits in the output register while the receiver stalls; loading of
// the next matrix goes on meanwhile.
module determinant_gauss_elimination_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,       // dimension
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // element
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,     // det_value
  output logic [0:0]  m_axis_tuser      // saturated
);

  dge_pkg::dp_cmd_t  cmd;
  dge_pkg::dp_stat_t stat;
  logic              sat;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tuser = sat;

  // sequencing
  dge_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  dge_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .elem_i      (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .det_o       (m_axis_tdata),
    .sat_o       (sat)
  );

endmodule

>>> bench/determinant_gauss_elimination_checker.sv
// checker: watches the streams, predicts determinants and compares the results
module determinant_gauss_elimination_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic [0:0]  m_tuser_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [63:0] det;
    logic        sat;
  } det_result_t;

  det_result_t det_queue[$];
  logic [63:0] work[dge_pkg::DEPTH];
  logic [3:0]  dim_reg;
  int unsigned load_cnt;
  bit          swap_odd;
  bit          sat_flag;

  task automatic report(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic int unsigned size_of(input logic [3:0] d);
    if (d == 0) return 1;
    if (d > dge_pkg::MAX_DIM) return dge_pkg::MAX_DIM;
    return 32'(d);
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // sign a magnitude, clamp on overflow
  function automatic logic [63:0] signed_sat(input logic [63:0] m, input bit neg,
                                             input bit over);
    if (neg) begin
      if (over || m > dge_pkg::Q_MIN) begin
        sat_flag = 1;
        return dge_pkg::Q_MIN;
      end
      return -m;
    end
    if (over || m[63]) begin
      sat_flag = 1;
      return dge_pkg::Q_MAX;
    end
    return m;
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, abs64(a)} * {64'b0, abs64(b)};
    return signed_sat(p[95:32], a[63] ^ b[63], |p[127:96]);
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] q;
    if (abs64(b) == 0) return signed_sat(64'b0, a[63], 1);
    q = {32'b0, abs64(a), 32'b0} / {64'b0, abs64(b)};
    return signed_sat(q[63:0], a[63] ^ b[63], |q[127:64]);
  endfunction

  function automatic logic [63:0] fx_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) begin
      sat_flag = 1;
      return a[63] ? dge_pkg::Q_MIN : dge_pkg::Q_MAX;
    end
    return d;
  endfunction

  // gaussian elimination with row swaps on zero pivots
  function automatic logic [63:0] gauss_det(input int unsigned n);
    int unsigned r;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] prod;
    prod = dge_pkg::ONE_Q32;
    for (int unsigned j = 0; j + 1 < n; j++) begin
      for (int unsigned i = j + 1; i < n; i++) begin
        if (work[j*n+j] == 0) begin
          r = i;
          while (r < n && work[r*n+j] == 0) r++;
          if (r >= n) return 64'b0;
          for (int unsigned k = 0; k < n; k++) begin
            t = work[j*n+k];
            work[j*n+k] = work[r*n+k];
            work[r*n+k] = t;
          end
          swap_odd = !swap_odd;
        end
        m = fx_div(work[i*n+j], work[j*n+j]);
        for (int unsigned k = 0; k < n; k++)
          work[i*n+k] = fx_sub(work[i*n+k], fx_mul(work[j*n+k], m));
      end
    end
    for (int unsigned i = 0; i < n; i++) prod = fx_mul(prod, work[i*n+i]);
    return swap_odd ? fx_sub(64'b0, prod) : prod;
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    logic [63:0] det;
    det_result_t exp_res;
    if (!rst_ni) begin
      det_queue.delete();
      dim_reg = dge_pkg::DIM_RESET;
      load_cnt = 0;
      swap_odd = 0;
      sat_flag = 0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (det_queue.size() == 0) begin
          report($sformatf("unexpected result %h", m_tdata_i));
        end else begin
          exp_res = det_queue.pop_front();
          if (m_tdata_i !== exp_res.det)
            report($sformatf("det %h, expected %h", m_tdata_i, exp_res.det));
          if (m_tuser_i[0] !== exp_res.sat)
            report($sformatf("saturated %b, expected %b", m_tuser_i[0], exp_res.sat));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        n = size_of(dim_reg);
        if (load_cnt < n * n) begin
          work[load_cnt] = {{16{s_tdata_i[31]}}, s_tdata_i, 16'b0};
          load_cnt++;
        end
        if (s_tlast_i) begin
          for (int unsigned p = load_cnt; p < n * n; p++) work[p] = 64'b0;
          if (n == 1) det = work[0];
          else if (n == 2) det = fx_sub(fx_mul(work[0], work[3]), fx_mul(work[1], work[2]));
          else det = gauss_det(n);
          det_queue.push_back('{det: det, sat: sat_flag});
          load_cnt = 0;
          swap_odd = 0;
          sat_flag = 0;
        end
      end
      if (cfg_valid_i && cfg_ready_i) dim_reg = cfg_data_i;
      pending_o = det_queue.size();
    end
  end

endmodule

>>> bench/determinant_gauss_elimination_top_tb.sv
// testbench top: clock, reset, matrix stimulus and the verdict
module determinant_gauss_elimination_top_tb;
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // element
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // det_value
  logic [0:0]  m_axis_tuser;    // saturated
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_rx;
  int          item_count;
  logic [3:0]  cur_dim;

  determinant_gauss_elimination_top dut (.*);

  determinant_gauss_elimination_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls at random, or holds off fully during a long stretch
  always @(posedge clk_i)
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

  // one element transfer, with a random gap in front
  task automatic send_elem(input logic [31:0] d, input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    item_count++;
  endtask

  // wait for all results, let the block settle, then write the dimension
  task automatic set_dim(input logic [3:0] d);
    s_axis_tvalid <= 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= d;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 0;
    cur_dim = d;
  endtask

  function automatic logic [31:0] rand_elem();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(6 << 16) - (3 << 16);
    if (pick < 70) return 32'b0;
    if (pick < 85) return $urandom;
    return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
  endfunction

  // random matrix: mostly well formed, some early marks and excess elements
  task automatic send_matrix();
    int unsigned n;
    int unsigned cnt;
    int unsigned pick;
    n = (cur_dim == 0) ? 1 : (cur_dim > 8 ? 8 : cur_dim);
    cnt = n * n;
    pick = $urandom_range(99);
    if (pick < 8) cnt = $urandom_range(1, n * n);
    else if (pick < 14) cnt = n * n + $urandom_range(1, 4);
    for (int unsigned k = 1; k <= cnt; k++) send_elem(rand_elem(), k == cnt);
  endtask

  task automatic send_list(input logic [31:0] v[], input int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++) send_elem(v[k], k == cnt - 1);
  endtask

  initial begin
    logic [31:0] m[];
    int unsigned phase;
    int unsigned pick;
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_data_i = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    hold_rx = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    item_count = 0;
    cur_dim = 3;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, saturation, row swap, early mark, excess
    set_dim(1);
    send_elem(32'h7FFF_FFFF, 1);
    send_elem(32'h8000_0000, 1);
    set_dim(2);
    m = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    send_list(m, 4);
    m = '{32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h5, 32'h6};
    send_list(m, 6);
    set_dim(3);
    m = '{32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1_0000};
    send_list(m, 9);
    m = '{32'h1_0000, 32'h2_0000};
    send_list(m, 2);

    // random matrices over several sizes and idling phases
    phase = 0;
    while (item_count < 1650) begin
      pick = $urandom_range(99);
      if (pick < 4) set_dim(0);
      else if (pick < 8) set_dim($urandom_range(9, 15));
      else if (pick < 11) set_dim(8);
      else if (pick < 18) set_dim($urandom_range(5, 7));
      else set_dim($urandom_range(1, 4));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // long receiver hold-off while small matrices keep coming
      if (phase == 5) begin
        set_dim(1);
        fork
          begin
            hold_rx <= 1;
            repeat (400) @(posedge clk_i);
            hold_rx <= 0;
          end
        join_none
      end
      repeat ($urandom_range(2, 6)) send_matrix();
      phase++;
    end
    s_axis_tvalid <= 0;

    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
